// ----- src/bplr_pkg.sv -----
// shared types, constants and defaults for the button press detector
`default_nettype none
package bplr_pkg;

	localparam int TICK_WIDTH_DEF = 32;
	localparam int TICK_IN_W      = 32;
	localparam int CFG_W          = 16;
	localparam int CFG_IDX_W      = 2;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT     = 2'd2;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd500;
	localparam logic [CFG_W-1:0] REPEAT_RST     = 16'd200;

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_DEBOUNCE = 2'd1,
		PH_PRESSED  = 2'd2,
		PH_REPEAT   = 2'd3
	} phase_t;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_ticks;
		logic [CFG_W-1:0] long_press_ticks;
		logic [CFG_W-1:0] repeat_ticks;
	} cfg_t;

	typedef struct packed {
		logic       press_event;
		logic       long_press_event;
		logic       repeat_event;
		logic [1:0] phase;
	} result_t;

endpackage
`default_nettype wire

// ----- src/bplr_if.sv -----
// valid/ready channel interfaces for polls and results
`default_nettype none
interface bplr_poll_if;
	logic        valid;
	logic        ready;
	logic        button_level;
	logic [31:0] now_tick;

	modport source (output valid, button_level, now_tick, input ready);
	modport sink (input valid, button_level, now_tick, output ready);
endinterface

interface bplr_result_if;
	logic       valid;
	logic       ready;
	logic       press_event;
	logic       long_press_event;
	logic       repeat_event;
	logic [1:0] phase;

	modport source (output valid, press_event, long_press_event, repeat_event, phase,
		input ready);
	modport sink (input valid, press_event, long_press_event, repeat_event, phase,
		output ready);
endinterface
`default_nettype wire

// ----- src/bplr_cfg.sv -----
// configuration registers for debounce, long-press and repeat times
`default_nettype none
module bplr_cfg
	import bplr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [CFG_W-1:0]     wr_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks   <= DEBOUNCE_RST;
			cfg_q.long_press_ticks <= LONG_PRESS_RST;
			cfg_q.repeat_ticks     <= REPEAT_RST;
		end else if (wr_en) begin
			// unused index is dropped
			unique case (wr_index)
				REG_DEBOUNCE:   cfg_q.debounce_ticks   <= wr_data;
				REG_LONG_PRESS: cfg_q.long_press_ticks <= wr_data;
				REG_REPEAT:     cfg_q.repeat_ticks     <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ----- src/bplr_core.sv -----
// phase machine, tick mark and elapsed-time compares
`default_nettype none
module bplr_core
	import bplr_pkg::*;
#(
	parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire logic                 button_level,
	input  wire logic [TICK_IN_W-1:0] now_tick,
	input  cfg_t                      cfg,
	output result_t                   res
);

	localparam int CMP_W = (TICK_WIDTH > CFG_W) ? TICK_WIDTH : CFG_W;

	phase_t                  phase_q;
	phase_t                  phase_d;
	logic [TICK_WIDTH-1:0]   mark_q;
	logic [TICK_WIDTH-1:0]   now_t;
	logic [TICK_WIDTH-1:0]   elapsed;
	logic [TICK_WIDTH+TICK_IN_W-1:0] now_wide;
	logic [TICK_WIDTH+CFG_W-1:0]     elapsed_wide;
	logic [TICK_WIDTH+CFG_W-1:0]     deb_wide;
	logic [TICK_WIDTH+CFG_W-1:0]     long_wide;
	logic [TICK_WIDTH+CFG_W-1:0]     rep_wide;
	logic                    gt_debounce;
	logic                    gt_long;
	logic                    gt_repeat;
	logic                    mark_load;

	// fit the tick to the mark width, wrapping modulo 2^TICK_WIDTH
	assign now_wide = {{TICK_WIDTH{1'b0}}, now_tick};
	assign now_t    = now_wide[TICK_WIDTH-1:0];
	assign elapsed  = now_t - mark_q;

	assign elapsed_wide = {{CFG_W{1'b0}}, elapsed};
	assign deb_wide     = {{TICK_WIDTH{1'b0}}, cfg.debounce_ticks};
	assign long_wide    = {{TICK_WIDTH{1'b0}}, cfg.long_press_ticks};
	assign rep_wide     = {{TICK_WIDTH{1'b0}}, cfg.repeat_ticks};

	assign gt_debounce = elapsed_wide[CMP_W-1:0] > deb_wide[CMP_W-1:0];
	assign gt_long     = elapsed_wide[CMP_W-1:0] > long_wide[CMP_W-1:0];
	assign gt_repeat   = elapsed_wide[CMP_W-1:0] > rep_wide[CMP_W-1:0];

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (button_level) phase_d = PH_DEBOUNCE;
			end
			PH_DEBOUNCE: begin
				if (gt_debounce) phase_d = button_level ? PH_PRESSED : PH_IDLE;
			end
			PH_PRESSED: begin
				if (!button_level) phase_d = PH_IDLE;
				else if (gt_long) phase_d = PH_REPEAT;
			end
			PH_REPEAT: begin
				if (!button_level) phase_d = PH_IDLE;
			end
		endcase
	end

	always_comb begin
		mark_load            = 1'b0;
		res.press_event      = 1'b0;
		res.long_press_event = 1'b0;
		res.repeat_event     = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				mark_load = button_level;
			end
			PH_DEBOUNCE: begin
				mark_load       = gt_debounce && button_level;
				res.press_event = gt_debounce && button_level;
			end
			PH_PRESSED: begin
				mark_load            = button_level && gt_long;
				res.long_press_event = button_level && gt_long;
			end
			PH_REPEAT: begin
				mark_load        = button_level && gt_repeat;
				res.repeat_event = button_level && gt_repeat;
			end
		endcase
		res.phase = phase_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			mark_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			if (mark_load) mark_q <= now_t;
		end
	end

endmodule
`default_nettype wire

// ----- src/button_press_long_repeat_fsm.sv -----
// button press, long-press and auto-repeat detector, top level
// an accepted poll is held in the input register; its result is then held in the result register
// throughput: one poll per cycle; a held result stalls input only once the
//   input register is full as well
// reset: arst_n clears phase to idle, the tick mark to zero and loads default times
`default_nettype none
module button_press_long_repeat_fsm
	import bplr_pkg::*;
#(
	parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	bplr_poll_if.sink                 poll,
	bplr_result_if.source             result,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [CFG_W-1:0]     wr_data
);

	cfg_t                 cfg;
	result_t              res;
	result_t              res_s2;
	logic                 valid_s1;
	logic                 valid_s2;
	logic                 level_s1;
	logic [TICK_IN_W-1:0] tick_s1;
	logic                 advance;
	logic                 step;

	bplr_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	assign advance    = !valid_s2 || result.ready;
	assign step       = valid_s1 && advance;
	assign poll.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.ready && poll.valid) begin
			level_s1 <= poll.button_level;
			tick_s1  <= poll.now_tick;
		end
	end

	bplr_core #(
		.TICK_WIDTH (TICK_WIDTH)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.button_level (level_s1),
		.now_tick     (tick_s1),
		.cfg          (cfg),
		.res          (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) res_s2 <= res;
	end

	assign result.valid            = valid_s2;
	assign result.press_event      = res_s2.press_event;
	assign result.long_press_event = res_s2.long_press_event;
	assign result.repeat_event     = res_s2.repeat_event;
	assign result.phase            = res_s2.phase;

endmodule
`default_nettype wire
